### rtl/bffe_pkg.sv
`timescale 1ns / 1ps

package bffe_pkg;

  localparam int MAX_SIDE_DEF = 32;
  localparam int SIDE_CFG_W = 6;
  localparam int REQ_W = 2;
  localparam int ROW_W = 5;
  localparam int COL_W = 5;
  localparam int CLASS_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD = 2'd0,
    REQ_FILL = 2'd1,
    REQ_READ = 2'd2
  } req_t;

  localparam logic [CLASS_W-1:0] C_OUTSIDE = 2'd0;
  localparam logic [CLASS_W-1:0] C_WALL    = 2'd1;
  localparam logic [CLASS_W-1:0] C_OPEN    = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ_WAIT,
    S_VIS_RD,
    S_VIS_CHK,
    S_POP,
    S_POP_WAIT
  } state_t;

  // border seeds first, then the four neighbours of a dequeued cell
  typedef enum logic [2:0] {
    ST_SEED_TOP,
    ST_SEED_LEFT,
    ST_SEED_BOT,
    ST_SEED_RIGHT,
    ST_NB_DOWN,
    ST_NB_RIGHT,
    ST_NB_UP,
    ST_NB_LEFT
  } step_t;

endpackage

### rtl/bffe_if.sv
`timescale 1ns / 1ps

interface bffe_in_if;
  import bffe_pkg::*;

  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   col;
  logic               is_wall;

  modport source (output valid, output req_type, output row, output col, output is_wall,
                  input ready);
  modport sink (input valid, input req_type, input row, input col, input is_wall,
                output ready);
endinterface

interface bffe_out_if;
  import bffe_pkg::*;

  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] cell_class;
  logic               is_read_data;

  modport source (output valid, output cell_class, output is_read_data, input ready);
  modport sink (input valid, input cell_class, input is_read_data, output ready);
endinterface

### rtl/bffe_ram.sv
`timescale 1ns / 1ps

module bffe_ram #(
  parameter int W = 2,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/bffe_nbr.sv
`timescale 1ns / 1ps

module bffe_nbr #(
  parameter int MAX_SIDE = bffe_pkg::MAX_SIDE_DEF,
  localparam int CW = $clog2(MAX_SIDE),
  localparam int SW = $clog2(MAX_SIDE + 1),
  localparam int IW = $clog2(MAX_SIDE * MAX_SIDE)
) (
  input  bffe_pkg::step_t step,
  input  logic [CW-1:0]   base_row,
  input  logic [CW-1:0]   base_col,
  input  logic [SW-1:0]   side,
  output logic [CW-1:0]   tgt_row,
  output logic [CW-1:0]   tgt_col,
  output logic [IW-1:0]   tgt_addr,
  output logic            tgt_ok
);
  import bffe_pkg::*;

  logic [CW-1:0] last;

  assign last = CW'(side - SW'(1));

  always_comb begin
    tgt_row = base_row;
    tgt_col = base_col;
    tgt_ok  = 1'b1;
    unique case (step)
      ST_SEED_TOP:   tgt_row = '0;
      ST_SEED_LEFT:  tgt_col = '0;
      ST_SEED_BOT:   tgt_row = last;
      ST_SEED_RIGHT: tgt_col = last;
      ST_NB_DOWN: begin
        tgt_row = CW'(base_row + CW'(1));
        tgt_ok  = (int'(base_row) + 1) < int'(side);
      end
      ST_NB_RIGHT: begin
        tgt_col = CW'(base_col + CW'(1));
        tgt_ok  = (int'(base_col) + 1) < int'(side);
      end
      ST_NB_UP: begin
        tgt_row = CW'(base_row - CW'(1));
        tgt_ok  = base_row != '0;
      end
      ST_NB_LEFT: begin
        tgt_col = CW'(base_col - CW'(1));
        tgt_ok  = base_col != '0;
      end
      default: tgt_ok = 1'b0;
    endcase
  end

  assign tgt_addr = IW'(int'(tgt_row) * MAX_SIDE + int'(tgt_col));

endmodule

### rtl/bffe_ctrl.sv
`timescale 1ns / 1ps

module bffe_ctrl #(
  parameter int MAX_SIDE = bffe_pkg::MAX_SIDE_DEF,
  localparam int CW = $clog2(MAX_SIDE),
  localparam int SW = $clog2(MAX_SIDE + 1),
  localparam int CELLS = MAX_SIDE * MAX_SIDE,
  localparam int IW = $clog2(CELLS),
  localparam int QW = $clog2(CELLS + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bffe_in_if.sink                         in_ch,
  bffe_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [bffe_pkg::SIDE_CFG_W-1:0] cfg_wdata,
  output logic                            g_we,
  output logic [IW-1:0]                   g_waddr,
  output logic [bffe_pkg::CLASS_W-1:0]    g_wdata,
  output logic [IW-1:0]                   g_raddr,
  input  logic [bffe_pkg::CLASS_W-1:0]    g_rdata,
  output logic                            q_we,
  output logic [IW-1:0]                   q_waddr,
  output logic [2*CW-1:0]                 q_wdata,
  output logic [IW-1:0]                   q_raddr,
  input  logic [2*CW-1:0]                 q_rdata,
  output bffe_pkg::step_t                 nb_step,
  output logic [CW-1:0]                   nb_base_row,
  output logic [CW-1:0]                   nb_base_col,
  output logic [SW-1:0]                   nb_side,
  input  logic [CW-1:0]                   nb_row,
  input  logic [CW-1:0]                   nb_col,
  input  logic [IW-1:0]                   nb_addr,
  input  logic                            nb_ok
);
  import bffe_pkg::*;

  localparam int SIDE_RST = (32 > MAX_SIDE) ? MAX_SIDE : 32;

  state_t               state_r, state_nxt;
  step_t                step_r, step_nxt;
  logic [SW-1:0]        side_r, side_nxt;
  logic [IW-1:0]        clr_r, clr_nxt;
  logic [QW-1:0]        head_r, head_nxt;
  logic [QW-1:0]        tail_r, tail_nxt;
  logic [CW-1:0]        base_row_r, base_row_nxt;
  logic [CW-1:0]        base_col_r, base_col_nxt;
  logic [IW-1:0]        vis_addr_r, vis_addr_nxt;
  logic [2*CW-1:0]      vis_rc_r, vis_rc_nxt;
  logic                 in_grid_r, in_grid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CLASS_W-1:0]   out_class_r, out_class_nxt;
  logic                 out_rd_r, out_rd_nxt;
  logic                 in_ready;
  logic                 adv;
  logic                 in_grid;
  logic [IW-1:0]        req_addr;
  logic [CW-1:0]        last;

  assign in_grid  = (int'(in_ch.row) < int'(side_r)) && (int'(in_ch.col) < int'(side_r));
  assign req_addr = IW'(int'(CW'(in_ch.row)) * MAX_SIDE + int'(CW'(in_ch.col)));
  assign last     = CW'(side_r - SW'(1));

  assign nb_step     = step_r;
  assign nb_base_row = base_row_r;
  assign nb_base_col = base_col_r;
  assign nb_side     = side_r;

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_class = out_class_r;
  assign out_ch.is_read_data = out_rd_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    side_nxt      = side_r;
    clr_nxt       = clr_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    base_row_nxt  = base_row_r;
    base_col_nxt  = base_col_r;
    vis_addr_nxt  = vis_addr_r;
    vis_rc_nxt    = vis_rc_r;
    in_grid_nxt   = in_grid_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_class_nxt = out_class_r;
    out_rd_nxt    = out_rd_r;
    g_we          = 1'b0;
    g_waddr       = vis_addr_r;
    g_wdata       = C_OUTSIDE;
    g_raddr       = nb_addr;
    q_we          = 1'b0;
    q_waddr       = tail_r[IW-1:0];
    q_wdata       = vis_rc_r;
    q_raddr       = head_r[IW-1:0];
    in_ready      = 1'b0;
    adv           = 1'b0;

    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        side_nxt = SW'(1);
      end else if (int'(cfg_wdata) > MAX_SIDE) begin
        side_nxt = SW'(MAX_SIDE);
      end else begin
        side_nxt = SW'(cfg_wdata);
      end
    end

    unique case (state_r)
      S_CLEAR: begin
        g_we    = 1'b1;
        g_waddr = clr_r;
        g_wdata = C_OPEN;
        clr_nxt = clr_r + IW'(1);
        if (clr_r == IW'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = !out_valid_r || out_ch.ready;
        g_raddr  = req_addr;
        if (in_ch.valid && in_ready) begin
          case (in_ch.req_type)
            REQ_LOAD: begin
              g_we          = in_grid;
              g_waddr       = req_addr;
              g_wdata       = in_ch.is_wall ? C_WALL : C_OPEN;
              out_valid_nxt = 1'b1;
              out_class_nxt = C_OUTSIDE;
              out_rd_nxt    = 1'b0;
            end
            REQ_READ: begin
              in_grid_nxt = in_grid;
              state_nxt   = S_READ_WAIT;
            end
            REQ_FILL: begin
              head_nxt     = '0;
              tail_nxt     = '0;
              base_row_nxt = '0;
              base_col_nxt = '0;
              step_nxt     = ST_SEED_TOP;
              state_nxt    = S_VIS_RD;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_class_nxt = C_OUTSIDE;
              out_rd_nxt    = 1'b0;
            end
          endcase
        end
      end
      S_READ_WAIT: begin
        out_valid_nxt = 1'b1;
        out_class_nxt = in_grid_r ? g_rdata : C_WALL;
        out_rd_nxt    = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_VIS_RD: begin
        vis_addr_nxt = nb_addr;
        vis_rc_nxt   = {nb_row, nb_col};
        if (nb_ok) begin
          state_nxt = S_VIS_CHK;
        end else begin
          adv = 1'b1;
        end
      end
      S_VIS_CHK: begin
        if (g_rdata == C_OPEN) begin
          g_we     = 1'b1;
          q_we     = 1'b1;
          tail_nxt = tail_r + QW'(1);
        end
        adv = 1'b1;
      end
      S_POP: begin
        if (head_r == tail_r) begin
          out_valid_nxt = 1'b1;
          out_class_nxt = C_OUTSIDE;
          out_rd_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end else begin
          head_nxt  = head_r + QW'(1);
          state_nxt = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        base_row_nxt = q_rdata[2*CW-1:CW];
        base_col_nxt = q_rdata[CW-1:0];
        step_nxt     = ST_NB_DOWN;
        state_nxt    = S_VIS_RD;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (adv) begin
      case (step_r)
        ST_SEED_RIGHT: begin
          if (base_row_r == last) begin
            state_nxt = S_POP;
          end else begin
            base_row_nxt = base_row_r + CW'(1);
            base_col_nxt = base_col_r + CW'(1);
            step_nxt     = ST_SEED_TOP;
            state_nxt    = S_VIS_RD;
          end
        end
        ST_NB_LEFT: state_nxt = S_POP;
        default: begin
          step_nxt  = step_t'(step_r + 3'd1);
          state_nxt = S_VIS_RD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      side_r      <= SW'(SIDE_RST);
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      side_r      <= side_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r      <= step_nxt;
    base_row_r  <= base_row_nxt;
    base_col_r  <= base_col_nxt;
    vis_addr_r  <= vis_addr_nxt;
    vis_rc_r    <= vis_rc_nxt;
    in_grid_r   <= in_grid_nxt;
    out_class_r <= out_class_nxt;
    out_rd_r    <= out_rd_nxt;
  end

endmodule

### rtl/border_flood_fill_enclosed.sv
// load and unknown request: result in the cycle after acceptance; read: via S_READ_WAIT;
//   one load per cycle while the output is not stalled; fill: S_VIS_RD and S_VIS_CHK per
//   in-range probe, S_VIS_RD per out-of-range probe, S_POP and S_POP_WAIT per dequeued cell;
//   input not ready until its result is issued; reset: synchronous, active low; afterwards
//   a clearing pass writes every cell open, input not ready; side resets to min(32, MAX_SIDE)
`timescale 1ns / 1ps

module border_flood_fill_enclosed #(
  parameter int MAX_SIDE = bffe_pkg::MAX_SIDE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bffe_in_if.sink                         in_ch,
  bffe_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [bffe_pkg::SIDE_CFG_W-1:0] cfg_wdata
);
  import bffe_pkg::*;

  localparam int CW = $clog2(MAX_SIDE);
  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int IW = $clog2(CELLS);

  logic               g_we;
  logic [IW-1:0]      g_waddr;
  logic [CLASS_W-1:0] g_wdata;
  logic [IW-1:0]      g_raddr;
  logic [CLASS_W-1:0] g_rdata;
  logic               q_we;
  logic [IW-1:0]      q_waddr;
  logic [2*CW-1:0]    q_wdata;
  logic [IW-1:0]      q_raddr;
  logic [2*CW-1:0]    q_rdata;
  step_t              nb_step;
  logic [CW-1:0]      nb_base_row;
  logic [CW-1:0]      nb_base_col;
  logic [SW-1:0]      nb_side;
  logic [CW-1:0]      nb_row;
  logic [CW-1:0]      nb_col;
  logic [IW-1:0]      nb_addr;
  logic               nb_ok;

  bffe_ram #(.W(CLASS_W), .DEPTH(CELLS)) u_grid (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  bffe_ram #(.W(2 * CW), .DEPTH(CELLS)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  bffe_nbr #(.MAX_SIDE(MAX_SIDE)) u_nbr (
    .step     (nb_step),
    .base_row (nb_base_row),
    .base_col (nb_base_col),
    .side     (nb_side),
    .tgt_row  (nb_row),
    .tgt_col  (nb_col),
    .tgt_addr (nb_addr),
    .tgt_ok   (nb_ok)
  );

  bffe_ctrl #(.MAX_SIDE(MAX_SIDE)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .g_we        (g_we),
    .g_waddr     (g_waddr),
    .g_wdata     (g_wdata),
    .g_raddr     (g_raddr),
    .g_rdata     (g_rdata),
    .q_we        (q_we),
    .q_waddr     (q_waddr),
    .q_wdata     (q_wdata),
    .q_raddr     (q_raddr),
    .q_rdata     (q_rdata),
    .nb_step     (nb_step),
    .nb_base_row (nb_base_row),
    .nb_base_col (nb_base_col),
    .nb_side     (nb_side),
    .nb_row      (nb_row),
    .nb_col      (nb_col),
    .nb_addr     (nb_addr),
    .nb_ok       (nb_ok)
  );

endmodule

### rtl/bffe_chk.sv
`timescale 1ns / 1ps

module bffe_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [bffe_pkg::REQ_W-1:0]   in_req_type,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bffe_pkg::CLASS_W-1:0] out_cell_class,
  input logic                         out_is_read_data
);
  import bffe_pkg::*;

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cell_class != 2'd3)
    else $error("undefined cell class");

  a_non_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_read_data |-> out_cell_class == C_OUTSIDE)
    else $error("non-read transaction carries a class");

  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_LOAD |=> out_valid && !out_is_read_data)
    else $error("load transaction without its result");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_READ |-> ##2 out_valid && out_is_read_data)
    else $error("read transaction without its data");

endmodule

bind border_flood_fill_enclosed bffe_chk u_bffe_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_req_type      (in_ch.req_type),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_cell_class   (out_ch.cell_class),
  .out_is_read_data (out_ch.is_read_data)
);
